[rtl/sensor_frame_deframe_decode_macros.svh]
// assertion macros of the deframer, used by sfdd_frame
`ifndef SENSOR_FRAME_DEFRAME_DECODE_MACROS_SVH
`define SENSOR_FRAME_DEFRAME_DECODE_MACROS_SVH

// same-cycle implication
`define SFDD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdd check failed");

// next-cycle implication
`define SFDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdd check failed");

`endif

[rtl/sfdd_pkg.sv]
// types, constants and sizes of the report deframer
package sfdd_pkg;

  localparam int HEAD_BYTES = 12;
  localparam int HEAD_IDX_W = $clog2(HEAD_BYTES);

  localparam logic [7:0] DELIM       = 8'hFF;
  localparam logic [7:0] TYPE_TH     = 8'h42;
  localparam logic [7:0] TYPE_TS     = 8'h60;
  localparam logic [3:0] NEG_NIBBLE  = 4'h8;
  localparam logic [3:0] NIB_MASK    = 4'hF;
  localparam logic [7:0] LIMIT_RESET = 8'd200;
  localparam logic [7:0] MIN_FRAME   = 8'd12;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  typedef enum logic [1:0] {
    KIND_TEMP_HUM  = 2'd0,
    KIND_TIMESTAMP = 2'd1,
    KIND_UNKNOWN   = 2'd2,
    KIND_SHORT     = 2'd3
  } frame_kind_t;

  typedef logic [7:0] head_t [HEAD_BYTES];

  typedef struct packed {
    frame_kind_t        frame_kind;
    logic               checksum_ok;
    logic [7:0]         frame_length;
    logic [3:0]         sensor_id;
    logic signed [12:0] temperature_tenths;
    logic [7:0]         humidity;
    logic [7:0]         minute;
    logic [7:0]         hour;
    logic [7:0]         day;
    logic [7:0]         month;
    logic [7:0]         year_offset;
  } result_t;

endpackage

[rtl/sfdd_decode.sv]
// decode of a closed frame: checksum compare and type fields
module sfdd_decode
  import sfdd_pkg::*;
(
  input  logic [7:0]  byte_count,
  input  logic [15:0] running_sum,
  input  logic [7:0]  last_byte,
  input  logic [7:0]  second_last_byte,
  input  head_t       frame_head,
  output result_t     result
);

  logic [15:0] sum;
  logic [15:0] want;
  logic [11:0] mag;
  logic        neg;

  assign sum  = running_sum - {8'd0, last_byte} - {8'd0, second_last_byte};
  assign want = {frame_head[11], frame_head[10]};
  assign mag  = {frame_head[4][3:0], frame_head[3]};
  assign neg  = (frame_head[4][7:4] == NEG_NIBBLE);

  always_comb begin
    result = '0;
    result.frame_length = byte_count;
    if (byte_count < MIN_FRAME) begin
      result.frame_kind = KIND_SHORT;
    end else begin
      result.checksum_ok = (sum == want);
      if (frame_head[1] == TYPE_TH) begin
        result.frame_kind = KIND_TEMP_HUM;
        result.sensor_id  = frame_head[2][3:0] & NIB_MASK;
        result.temperature_tenths = neg ? (13'sd0 - $signed({1'b0, mag}))
                                        : $signed({1'b0, mag});
        result.humidity   = frame_head[5];
      end else if (frame_head[1] == TYPE_TS) begin
        result.frame_kind  = KIND_TIMESTAMP;
        result.minute      = frame_head[4];
        result.hour        = frame_head[5];
        result.day         = frame_head[6];
        result.month       = frame_head[7];
        result.year_offset = frame_head[8];
      end else begin
        result.frame_kind = KIND_UNKNOWN;
      end
    end
  end

endmodule

[rtl/sfdd_frame.sv]
// frame state: head bytes, count, running sum and closing decode
`include "sensor_frame_deframe_decode_macros.svh"

module sfdd_frame
  import sfdd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] data_byte,
  input  logic       report_end,
  input  logic [7:0] overflow_limit,
  output logic       emit,
  output result_t    result
);

  head_t       frame_head;
  logic [7:0]  byte_count;
  logic [15:0] running_sum;
  logic [7:0]  last_byte;
  logic [7:0]  second_last_byte;

  logic [7:0]  byte_count_next;
  logic [15:0] running_sum_next;
  logic [7:0]  last_byte_next;
  logic [7:0]  second_last_byte_next;
  logic        is_delim;
  logic        head_we;

  assign is_delim = (data_byte == DELIM);
  assign emit     = is_delim && (byte_count != 8'd0);
  assign head_we  = !is_delim && (byte_count < 8'(HEAD_BYTES));

  always_comb begin
    byte_count_next       = byte_count;
    running_sum_next      = running_sum;
    last_byte_next        = last_byte;
    second_last_byte_next = second_last_byte;
    if (is_delim) begin
      byte_count_next       = '0;
      running_sum_next      = '0;
      last_byte_next        = '0;
      second_last_byte_next = '0;
    end else begin
      if (byte_count != COUNT_MAX) begin
        byte_count_next = byte_count + 8'd1;
      end
      running_sum_next      = running_sum + {8'd0, data_byte};
      second_last_byte_next = last_byte;
      last_byte_next        = data_byte;
    end
    // discard at report end when over the limit
    if (report_end && (byte_count_next > overflow_limit)) begin
      byte_count_next       = '0;
      running_sum_next      = '0;
      last_byte_next        = '0;
      second_last_byte_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      running_sum      <= '0;
      last_byte        <= '0;
      second_last_byte <= '0;
    end else if (advance) begin
      byte_count       <= byte_count_next;
      running_sum      <= running_sum_next;
      last_byte        <= last_byte_next;
      second_last_byte <= second_last_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_we) begin
      frame_head[byte_count[HEAD_IDX_W-1:0]] <= data_byte;
    end
  end

  sfdd_decode u_decode (
    .byte_count       (byte_count),
    .running_sum      (running_sum),
    .last_byte        (last_byte),
    .second_last_byte (second_last_byte),
    .frame_head       (frame_head),
    .result           (result)
  );

  `SFDD_ASSERT_NEXT(a_delim_clears, clk, rst, advance && is_delim, byte_count == 8'd0)
  `SFDD_ASSERT_NEXT(a_data_counts, clk, rst, advance && !is_delim && !report_end,
                    byte_count != 8'd0)
  `SFDD_ASSERT_NEXT(a_hold_idle, clk, rst, !advance,
                    $stable(byte_count) && $stable(running_sum))

endmodule

[rtl/sensor_frame_deframe_decode.sv]
// top level of the weather report deframer and decoder
//
//   port group   dir   tdata                        tuser / tlast
//   s_axis       in    data_byte                    tlast: report_end
//   m_axis       out   length, id, temp, ... year   tuser: frame_kind, checksum_ok
//   cfg          in    overflow_limit (8 bit)       -
//
// one byte per cycle while no result waits unaccepted; a byte goes input register -> frame state -> result register
// a closing delimiter's result is taken into the result register as the delimiter leaves the input register
// rst is synchronous and clears the frame count, sum and last bytes (not the head bytes); overflow_limit resets to 200
// while a result waits unaccepted no byte leaves the input register, and s_tready
// drops only while the input register holds a byte that cannot leave it
module sensor_frame_deframe_decode
  import sfdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // report_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_length[7:0], sensor_id[11:8], temperature_tenths[24:12], humidity[32:25],
  // minute[40:33], hour[48:41], day[56:49], month[64:57], year_offset[72:65], zeros
  output logic [79:0] m_tdata,
  output logic [2:0]  m_tuser,   // frame_kind[1:0], checksum_ok[2]
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;
  logic [7:0] overflow_limit;
  logic       advance;
  logic       emit;
  result_t    result;
  result_t    out_result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      overflow_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  sfdd_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .data_byte      (in_byte),
    .report_end     (in_end),
    .overflow_limit (overflow_limit),
    .emit           (emit),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_result <= result;
    end
  end

  assign m_tdata = {7'd0,
                    out_result.year_offset,
                    out_result.month,
                    out_result.day,
                    out_result.hour,
                    out_result.minute,
                    out_result.humidity,
                    out_result.temperature_tenths,
                    out_result.sensor_id,
                    out_result.frame_length};
  assign m_tuser = {out_result.checksum_ok, out_result.frame_kind};

endmodule
